/* hdl/tsct_pkg.sv */
// Package for the transient spike capture trigger.
// Holds field widths, default sizes, reset values, command codes and register indexes.
// No dependencies.
package tsct_pkg;

    localparam int CAPTURE_DEPTH_DEF = 16384;

    localparam int SAMPLE_W    = 16;
    localparam int INDEX_W     = 14;
    localparam int THRESHOLD_W = 17;
    localparam int POST_W      = 16;
    localparam int COUNT_W     = 32;
    localparam int CMD_W       = 2;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 64;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 17'd20000;
    localparam logic [POST_W-1:0]      POST_RST      = 16'd2000;

    localparam logic [CFG_IDX_W-1:0] REG_SPIKE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POST_TRIGGER    = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_REARM = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

endpackage

/* hdl/tsct_capture_ram.sv */
// Capture memory of the transient spike capture trigger.
// One write port and one read port with registered read data; depends on tsct_pkg.
module tsct_capture_ram #(
    parameter int DEPTH = tsct_pkg::CAPTURE_DEPTH_DEF,
    parameter int AW    = $clog2(tsct_pkg::CAPTURE_DEPTH_DEF)
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [tsct_pkg::SAMPLE_W-1:0] wdata,
    input  logic                          re,
    input  logic [AW-1:0]                 raddr,
    output logic [tsct_pkg::SAMPLE_W-1:0] rdata
);
    import tsct_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/transient_spike_capture_trigger.sv */
// Top level of the transient spike capture trigger: spike detection, capture control, output.
// Depends on tsct_pkg and tsct_capture_ram.
//
//   Channel   Signals                                  Direction  Purpose
//   config    cfg_we, cfg_index, cfg_data              in         threshold, post-trigger length
//   s_axis    tvalid, tready, tdata, tuser             in         commands and samples
//   m_axis    tvalid, tready, tdata                    out        one status transaction per command
//
// One transaction is accepted per cycle while s_axis_tready is high; its result passes through the
// read stage registers and is then loaded into the output register.
// The capture memory has one write and one read port, and a read and a push never share a cycle.
// Entries not yet written since reset read as zero through the write pointer and a wrap flag, so
// the block is ready right after reset with no clearing pass.
// A stalled output holds the result in the output register; one more transaction waits in the
// read stage, and s_axis_tready drops only when both are full.
module transient_spike_capture_trigger #(
    parameter int CAPTURE_DEPTH = tsct_pkg::CAPTURE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tsct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsct_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // sample[15:0], read_index[29:16], zero[31:30]
    input  logic [tsct_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command[1:0]
    input  logic [tsct_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // read_data[15:0], spike_seen[16], is_frozen[17], spike_total[49:18],
    // write_position[63:50]
    output logic [tsct_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import tsct_pkg::*;

    localparam int AW = $clog2(CAPTURE_DEPTH);
    localparam int XW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

    logic [THRESHOLD_W-1:0] thr_reg;
    logic [POST_W-1:0]      post_reg;

    logic [AW-1:0]          wptr_reg, wptr_next;
    logic                   wrapped_reg, wrapped_next;
    logic [SAMPLE_W-1:0]    prev_reg, prev_next;
    logic [SAMPLE_W-1:0]    older_reg, older_next;
    logic [POST_W-1:0]      hold_rem_reg, hold_rem_next;
    logic                   hold_active_reg, hold_active_next;
    logic                   frozen_reg, frozen_next;
    logic [COUNT_W-1:0]     spike_cnt_reg, spike_cnt_next;

    logic                   s1_valid_reg;
    logic                   s1_hit_reg;
    logic                   s1_spike_reg;
    logic                   s1_frozen_reg;
    logic [COUNT_W-1:0]     s1_count_reg;
    logic [INDEX_W-1:0]     s1_wpos_reg;

    logic                   m_valid_reg;
    logic [OUT_DATA_W-1:0]  m_data_reg;

    cmd_t                   cmd;
    logic [SAMPLE_W-1:0]    sample_in;
    logic [INDEX_W-1:0]     read_index;
    logic [XW-1:0]          idx_x;
    logic [XW-1:0]          wptr_x;
    logic                   in_accept;
    logic                   s1_move;
    logic                   push_en;
    logic                   read_en;
    logic                   read_hit;
    logic                   trig;
    logic signed [18:0]     dd;
    logic [17:0]            dd_abs;
    logic [POST_W-1:0]      rem_cur;
    logic                   act_cur;
    logic [SAMPLE_W-1:0]    ram_rdata;
    logic [SAMPLE_W-1:0]    read_data;
    logic [XW-1:0]          wpos_x;

    assign cmd        = cmd_t'(s_axis_tuser);
    assign sample_in  = s_axis_tdata[SAMPLE_W-1:0];
    assign read_index = s_axis_tdata[SAMPLE_W+INDEX_W-1:SAMPLE_W];

    assign s1_move       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign idx_x  = XW'(read_index);
    assign wptr_x = XW'(wptr_reg);

    assign push_en  = in_accept && (cmd == CMD_PUSH) && !frozen_reg;
    assign read_hit = (idx_x < XW'(CAPTURE_DEPTH)) && (wrapped_reg || (idx_x < wptr_x));
    assign read_en  = in_accept && (cmd == CMD_READ) && read_hit;

    assign dd = {{3{sample_in[SAMPLE_W-1]}}, sample_in}
              - {{2{prev_reg[SAMPLE_W-1]}}, prev_reg, 1'b0}
              + {{3{older_reg[SAMPLE_W-1]}}, older_reg};
    assign dd_abs = dd[18] ? 18'(-dd) : dd[17:0];

    assign trig    = (dd_abs > {1'b0, thr_reg}) && !hold_active_reg;
    assign rem_cur = trig ? post_reg : hold_rem_reg;
    assign act_cur = trig || hold_active_reg;

    always_comb
    begin
        wptr_next        = wptr_reg;
        wrapped_next     = wrapped_reg;
        prev_next        = prev_reg;
        older_next       = older_reg;
        hold_rem_next    = hold_rem_reg;
        hold_active_next = hold_active_reg;
        frozen_next      = frozen_reg;
        spike_cnt_next   = spike_cnt_reg;
        if (push_en)
        begin
            if (wptr_reg == AW'(CAPTURE_DEPTH - 1))
            begin
                wptr_next    = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                wptr_next = wptr_reg + 1'b1;
            end
            older_next = prev_reg;
            prev_next  = sample_in;
            if (trig)
            begin
                spike_cnt_next = spike_cnt_reg + 1'b1;
            end
            if (act_cur)
            begin
                if (rem_cur <= POST_W'(1))
                begin
                    hold_rem_next    = '0;
                    hold_active_next = 1'b0;
                    frozen_next      = 1'b1;
                end
                else
                begin
                    hold_rem_next    = rem_cur - 1'b1;
                    hold_active_next = 1'b1;
                end
            end
        end
        else if (in_accept && (cmd == CMD_REARM))
        begin
            frozen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESHOLD_RST;
            post_reg <= POST_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPIKE_THRESHOLD: thr_reg  <= cfg_data[THRESHOLD_W-1:0];
                REG_POST_TRIGGER:    post_reg <= cfg_data[POST_W-1:0];
                default:             thr_reg  <= thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg        <= '0;
            wrapped_reg     <= 1'b0;
            prev_reg        <= '0;
            older_reg       <= '0;
            hold_rem_reg    <= '0;
            hold_active_reg <= 1'b0;
            frozen_reg      <= 1'b0;
            spike_cnt_reg   <= '0;
        end
        else
        begin
            wptr_reg        <= wptr_next;
            wrapped_reg     <= wrapped_next;
            prev_reg        <= prev_next;
            older_reg       <= older_next;
            hold_rem_reg    <= hold_rem_next;
            hold_active_reg <= hold_active_next;
            frozen_reg      <= frozen_next;
            spike_cnt_reg   <= spike_cnt_next;
        end
    end

    tsct_capture_ram #(
        .DEPTH (CAPTURE_DEPTH),
        .AW    (AW)
    ) u_capture_ram (
        .clk   (clk),
        .we    (push_en),
        .waddr (wptr_reg),
        .wdata (sample_in),
        .re    (read_en),
        .raddr (idx_x[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign wpos_x = XW'(wptr_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_hit_reg    <= read_en;
            s1_spike_reg  <= push_en && trig;
            s1_frozen_reg <= frozen_next;
            s1_count_reg  <= spike_cnt_next;
            s1_wpos_reg   <= wpos_x[INDEX_W-1:0];
        end
    end

    assign read_data = s1_hit_reg ? ram_rdata : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_valid_reg)
        begin
            m_data_reg <= {s1_wpos_reg, s1_count_reg, s1_frozen_reg, s1_spike_reg, read_data};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_hold_not_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !(hold_active_reg && frozen_reg))
        else $error("Countdown is active while the capture is frozen.");

    a_hold_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        hold_active_reg |-> (hold_rem_reg != '0))
        else $error("Countdown is active with nothing remaining.");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |-> !in_accept)
        else $error("Transaction accepted while the read stage is stalled.");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((spike_cnt_reg == $past(spike_cnt_reg))
               || (spike_cnt_reg == $past(spike_cnt_reg) + 1'b1)))
        else $error("Spike count moved by more than one.");

    a_freeze_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frozen_reg) |-> $past(push_en))
        else $error("Capture froze without a push transaction.");

endmodule

/* verif/tsct_status_checker.sv */
// Scoreboard for the transient spike capture trigger testbench.
// Watches the configuration port and both stream channels, predicts every status transaction
// and compares it with what the block returns. Depends on tsct_pkg.
module tsct_status_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tsct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsct_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [tsct_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [tsct_pkg::CMD_W-1:0]      s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [tsct_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                              fail_count,
    output int                              pending,
    output logic                            capture_frozen,
    output int                              results_checked,
    output int                              freeze_events,
    output int                              pointer_wraps,
    output logic [tsct_pkg::COUNT_W-1:0]    spike_count
);
    import tsct_pkg::*;

    // Same bit layout as m_axis_tdata, highest field first.
    typedef struct packed {
        logic [INDEX_W-1:0]        write_position;
        logic [COUNT_W-1:0]        spike_total;
        logic                      is_frozen;
        logic                      spike_seen;
        logic signed [SAMPLE_W-1:0] read_data;
    } status_t;

    logic [SAMPLE_W-1:0]        capture_mem [0:CAPTURE_DEPTH_DEF-1];
    logic [INDEX_W-1:0]         wr_ptr;
    logic signed [SAMPLE_W-1:0] last_smp;
    logic signed [SAMPLE_W-1:0] prior_smp;
    logic [POST_W-1:0]          hold_left;
    logic                       hold_on;
    logic [THRESHOLD_W-1:0]     thr_reg;
    logic [POST_W-1:0]          post_reg;

    status_t expected_status_q[$];
    status_t exp_st;
    status_t got_st;

    task automatic predict_status(input cmd_t cmd, input logic signed [SAMPLE_W-1:0] smp,
                                  input logic [INDEX_W-1:0] idx, output status_t st);
        int d2;
        st = '0;
        case (cmd)
            CMD_PUSH:
                if (!capture_frozen)
                begin
                    capture_mem[wr_ptr] = smp;
                    if (&wr_ptr)
                        pointer_wraps++;
                    wr_ptr = wr_ptr + 1'b1;
                    d2 = int'(smp) - 2 * int'(last_smp) + int'(prior_smp);
                    if (d2 < 0)
                        d2 = -d2;
                    prior_smp = last_smp;
                    last_smp = smp;
                    if (d2 > int'(thr_reg) && !hold_on)
                    begin
                        spike_count = spike_count + 1'b1;
                        hold_on = 1'b1;
                        hold_left = post_reg;
                        st.spike_seen = 1'b1;
                    end
                    // The trigger sample itself is the first one of the post-trigger run.
                    if (hold_on)
                    begin
                        if (hold_left <= 1)
                        begin
                            hold_left = '0;
                            hold_on = 1'b0;
                            capture_frozen = 1'b1;
                            freeze_events++;
                        end
                        else
                        begin
                            hold_left = hold_left - 1'b1;
                        end
                    end
                end
            CMD_READ:
                st.read_data = capture_mem[idx];
            CMD_REARM:
                capture_frozen = 1'b0;
            default:
                ;
        endcase
        st.is_frozen = capture_frozen;
        st.spike_total = spike_count;
        st.write_position = wr_ptr;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPTURE_DEPTH_DEF; i++)
                capture_mem[i] = '0;
            wr_ptr = '0;
            last_smp = '0;
            prior_smp = '0;
            hold_left = '0;
            hold_on = 1'b0;
            capture_frozen = 1'b0;
            spike_count = '0;
            thr_reg = THRESHOLD_RST;
            post_reg = POST_RST;
            expected_status_q.delete();
            pending = 0;
            fail_count = 0;
            results_checked = 0;
            freeze_events = 0;
            pointer_wraps = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_SPIKE_THRESHOLD)
                    thr_reg = cfg_data;
                else if (cfg_index == REG_POST_TRIGGER)
                    post_reg = cfg_data[POST_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_status(cmd_t'(s_axis_tuser), s_axis_tdata[SAMPLE_W-1:0],
                               s_axis_tdata[SAMPLE_W +: INDEX_W], exp_st);
                expected_status_q.push_back(exp_st);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_st = m_axis_tdata;
                if (expected_status_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: status transaction with none expected: %h", $time,
                                 m_axis_tdata);
                end
                else
                begin
                    exp_st = expected_status_q.pop_front();
                    results_checked++;
                    if (got_st.read_data !== exp_st.read_data
                        || got_st.spike_seen !== exp_st.spike_seen
                        || got_st.is_frozen !== exp_st.is_frozen
                        || got_st.spike_total !== exp_st.spike_total
                        || got_st.write_position !== exp_st.write_position)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: status mismatch, expected read_data=%0d spike_seen=%0b",
                                     $time, exp_st.read_data, exp_st.spike_seen,
                                     " is_frozen=%0b spike_total=%0d write_position=%0d",
                                     exp_st.is_frozen, exp_st.spike_total, exp_st.write_position);
                            $display("%0t: got read_data=%0d spike_seen=%0b", $time,
                                     got_st.read_data, got_st.spike_seen,
                                     " is_frozen=%0b spike_total=%0d write_position=%0d",
                                     got_st.is_frozen, got_st.spike_total, got_st.write_position);
                        end
                    end
                end
            end
            pending = expected_status_q.size();
        end
    end

endmodule

/* verif/tb_transient_spike_capture_trigger.sv */
// Testbench top for the transient spike capture trigger.
// Drives register writes, command transactions and output back-pressure, and gives the verdict.
// Depends on tsct_pkg, transient_spike_capture_trigger and tsct_status_checker.
module tb_transient_spike_capture_trigger;
    import tsct_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int                 fail_count;
    int                 pending;
    logic               capture_frozen;
    int                 results_checked;
    int                 freeze_events;
    int                 pointer_wraps;
    logic [COUNT_W-1:0] spike_count;

    logic signed [SAMPLE_W-1:0] wave_level = '0;
    int wave_step = 100;
    int items_sent = 0;
    int settings_used = 1;
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    bit no_idle = 1'b0;
    bit long_hold_request = 1'b0;
    bit long_hold_done = 1'b0;
    int rx_stall_left = 0;
    int rx_hold_left = 0;

    transient_spike_capture_trigger dut (.*);

    tsct_status_checker status_check (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (long_hold_request && !long_hold_done)
        begin
            long_hold_done = 1'b1;
            rx_hold_left = 80;
        end
        if (no_idle)
        begin
            m_axis_tready <= 1'b1;
        end
        else if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(0, 9) == 0)
        begin
            rx_stall_left = $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Every task below starts and returns at a falling edge.
    task automatic send_item(input cmd_t cmd, input logic signed [SAMPLE_W-1:0] smp,
                             input logic [INDEX_W-1:0] idx);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {2'b00, idx, smp};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic idle_cycles(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [THRESHOLD_W-1:0] thr, input logic [POST_W-1:0] post);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        write_reg(REG_SPIKE_THRESHOLD, thr);
        write_reg(REG_POST_TRIGGER, {1'b0, post});
        settings_used++;
    endtask

    // Mostly a smooth waveform with occasional jumps, so triggers and freezes come often.
    task automatic random_phase(input logic [THRESHOLD_W-1:0] thr, input logic [POST_W-1:0] post,
                                input int step, input int n_items, input bit squeeze);
        int counted;
        int pick;
        int delta;
        logic [31:0] r;
        cmd_t cmd;
        logic signed [SAMPLE_W-1:0] smp;
        logic [INDEX_W-1:0] idx;
        configure(thr, post);
        wave_step = step;
        counted = 0;
        while (counted < n_items)
        begin
            if (counted % 40 == 0)
            begin
                tx_idle_on = !no_idle && $urandom_range(0, 2) != 0;
                rx_idle_on = $urandom_range(0, 2) != 0;
            end
            if (squeeze && counted == 30)
                long_hold_request = 1'b1;
            pick = $urandom_range(0, 99);
            if (capture_frozen)
            begin
                if (pick < 60)
                    cmd = CMD_REARM;
                else if (pick < 80)
                    cmd = CMD_READ;
                else if (pick < 95)
                    cmd = CMD_PUSH;
                else
                    cmd = CMD_NOP;
            end
            else
            begin
                if (pick < 70)
                    cmd = CMD_PUSH;
                else if (pick < 88)
                    cmd = CMD_READ;
                else if (pick < 95)
                    cmd = CMD_REARM;
                else
                    cmd = CMD_NOP;
            end
            r = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                delta = int'($urandom_range(0, 2 * wave_step)) - wave_step;
                smp = wave_level + delta[SAMPLE_W-1:0];
            end
            else if (pick < 90)
            begin
                smp = r[SAMPLE_W-1:0];
            end
            else if (pick[0])
            begin
                smp = 16'sh7FFF;
            end
            else
            begin
                smp = 16'sh8000;
            end
            idx = $urandom_range(0, 1) ? r[29:16] : {4'b0000, r[25:16]};
            counted++;
            if (cmd == CMD_PUSH && !capture_frozen)
                wave_level = smp;
            if (tx_idle_on && $urandom_range(0, 7) == 0)
                idle_cycles($urandom_range(1, 11));
            send_item(cmd, smp, idx);
        end
    endtask

    initial
    begin
        logic [31:0] r;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_NOP;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: plain pushes, reads of written and untouched entries, idle commands.
        send_item(CMD_PUSH, 16'sd100, '0);
        send_item(CMD_PUSH, -16'sd100, 14'h3FFF);
        send_item(CMD_READ, '0, 14'd0);
        send_item(CMD_READ, 16'shFFFF, 14'd1);
        send_item(CMD_READ, '0, 14'h3FFF);
        send_item(CMD_NOP, '0, '0);
        send_item(CMD_REARM, '0, '0);

        // Zero post-trigger length freezes on the trigger sample; pushes while frozen are dropped.
        configure('0, '0);
        send_item(CMD_PUSH, 16'sd5, '0);
        send_item(CMD_PUSH, 16'sd7, '0);
        send_item(CMD_READ, '0, 14'd2);
        send_item(CMD_READ, '0, 14'd3);
        send_item(CMD_REARM, '0, '0);
        send_item(CMD_PUSH, 16'sh8000, '0);
        send_item(CMD_REARM, '0, '0);
        send_item(CMD_PUSH, 16'sh7FFF, '0);
        send_item(CMD_REARM, '0, '0);
        send_item(CMD_PUSH, 16'sh8000, '0);
        send_item(CMD_REARM, '0, '0);

        // The largest possible second difference against the highest thresholds.
        configure(17'h1FFFF, 16'hFFFF);
        send_item(CMD_PUSH, 16'sh7FFF, '0);
        send_item(CMD_PUSH, 16'sh8000, '0);
        configure(17'h1FFFD, 16'd3);
        send_item(CMD_PUSH, 16'sd0, '0);
        send_item(CMD_PUSH, 16'sh7FFF, '0);
        send_item(CMD_PUSH, 16'sd0, '0);
        send_item(CMD_READ, '0, 14'd9);

        // A short burst of random pushes with idling on both sides.
        configure(17'h1FFFF, 16'hFFFF);
        send_item(CMD_REARM, '0, '0);
        rx_idle_on = 1'b1;
        repeat (24)
        begin
            r = $urandom;
            if ($urandom_range(0, 15) == 0)
                idle_cycles($urandom_range(1, 11));
            send_item(CMD_PUSH, r[SAMPLE_W-1:0], r[29:16]);
        end
        send_item(CMD_READ, '0, 14'h3FFF);
        send_item(CMD_READ, '0, 14'd0);
        send_item(CMD_READ, '0, 14'd63);

        random_phase(THRESHOLD_W'($urandom_range(1000, 30000)), POST_W'($urandom_range(1, 8)),
                     300, 120, 1'b0);
        random_phase('0, 16'd1, 50, 120, 1'b0);
        random_phase(17'd1, '0, 20, 110, 1'b0);
        random_phase(THRESHOLD_W'($urandom_range(0, 17'h1FFFF)),
                     POST_W'($urandom_range(1, 16'hFFFF)), 1000, 110, 1'b0);
        random_phase(THRESHOLD_W'($urandom_range(100, 3000)), POST_W'($urandom_range(2, 40)),
                     200, 130, 1'b1);
        random_phase(17'h1FFFF, 16'd2, 500, 110, 1'b0);
        random_phase(17'h1FFFD, 16'd1, 800, 110, 1'b0);
        no_idle = 1'b1;
        random_phase(THRESHOLD_W'($urandom_range(500, 5000)), POST_W'($urandom_range(1, 16)),
                     300, 120, 1'b0);

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10)
            @(negedge clk);
        $display("Sent %0d command transactions under %0d register settings; %0d results checked.",
                 items_sent, settings_used, results_checked);
        $display("Spikes counted: %0d, capture freezes: %0d, write pointer wraps: %0d.",
                 spike_count, freeze_events, pointer_wraps);
        if (fail_count == 0 && pending == 0)
            $display("** transient_spike_capture_trigger: PASSED **");
        else
            $display("** transient_spike_capture_trigger: FAILED **");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Timeout with %0d status transactions still expected.", pending);
        $display("** transient_spike_capture_trigger: FAILED **");
        $finish;
    end

endmodule

/* transient_spike_capture_trigger.f */
hdl/tsct_pkg.sv
hdl/tsct_capture_ram.sv
hdl/transient_spike_capture_trigger.sv
verif/tsct_status_checker.sv
verif/tb_transient_spike_capture_trigger.sv
